// File: rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// shared types and constants for the byte ring fifo with rts throttle
// ----------------------------------------------------------------------------
package brf_pkg;

   localparam int BRF_DEPTH = 64;
   localparam int BYTE_W    = 8;
   localparam int CNT_W     = 6;
   localparam int CSR_W     = 6;

   localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd60;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef enum logic [0:0] {
      REG_THROTTLE_LIMIT      = 1'b0,
      REG_FLOW_CONTROL_ENABLE = 1'b1
   } csr_index_type;

endpackage

// File: rtl/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module brf_ram #(
   parameter int WIDTH      = 8,
   parameter int DEPTH      = 64,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  write_enable,
   input  logic [ADDR_WIDTH-1:0] write_addr,
   input  logic [WIDTH-1:0]      write_data,
   input  logic                  read_enable,
   input  logic [ADDR_WIDTH-1:0] read_addr,
   output logic [WIDTH-1:0]      read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// File: rtl/byte_ring_fifo_with_rts_throttle.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_rts_throttle
// byte ring fifo with message admission check and rts hold flag
//
// a push gives its single result in the cycle after it is accepted
// a pop gives its first result in the cycle after acceptance, then one byte per
// cycle while rsp_stall is low, each byte coming from one ram read
// the next item is accepted in the cycle the previous item's last result leaves
// reset (synchronous) clears indexes, message state and hold flag, sets the
// throttle limit to 60 and enables flow control; ram contents are not cleared
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_rts_throttle
   import brf_pkg::*;
#(
   parameter int DEPTH = BRF_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   // item input
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_first_of_message,
   input  logic [CNT_W-1:0]  req_message_length,
   input  logic [CNT_W-1:0]  req_pop_count,
   // result output
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_out_valid,
   output logic              rsp_last_of_run,
   output logic              rsp_push_accepted,
   output logic [CNT_W-1:0]  rsp_used_count,
   output logic              rsp_rts_hold,
   // configuration
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_write_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = (IW > CNT_W) ? IW : CNT_W;
   localparam logic [IW:0]   DEPTH_X  = (IW+1)'(DEPTH);
   localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
   localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 1);

   function automatic logic [IW-1:0] bump(input logic [IW-1:0] idx);
      logic [IW-1:0] r;
      if (idx == IDX_LAST) r = '0;
      else r = idx + 1'b1;
      return r;
   endfunction

   function automatic logic [CW-1:0] fill(input logic [IW-1:0] w, input logic [IW-1:0] r);
      logic [IW:0] d;
      if (w >= r) d = {1'b0, w} - {1'b0, r};
      else d = {1'b0, w} + DEPTH_X - {1'b0, r};
      return CW'(d[IW-1:0]);
   endfunction

   // control state
   logic [IW-1:0]    wr_idx_ff, wr_idx_in;
   logic [IW-1:0]    rd_idx_ff, rd_idx_in;
   logic             hold_ff, hold_in;
   logic             drop_ff, drop_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic             fc_en_ff, fc_en_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // result payload
   logic             bvalid_ff, bvalid_in;
   logic             last_ff, last_in;
   logic             acc_ff, acc_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             rts_ff, rts_in;

   // ram side
   logic              ram_we;
   logic              ram_re;
   logic [BYTE_W-1:0] ram_q;

   logic             slot_free;
   logic             req_accept;
   logic             cont_read;
   logic [CW-1:0]    avail;
   logic [CW-1:0]    limit_x;
   logic [CW-1:0]    room;
   logic [CW-1:0]    take;
   logic [CNT_W-1:0] take_n;
   logic [IW-1:0]    rd_next;
   logic [CW-1:0]    used_rd;
   logic             hold_rd;
   logic             hold_empty;
   logic             new_msg;
   logic [CNT_W-1:0] msg_len;
   logic             store;
   logic [IW-1:0]    wr_next;
   logic [CW-1:0]    used_push;
   logic             hold_push;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (remain_ff != '0) || !slot_free;
   assign req_accept = req_valid && !req_stall;
   assign cont_read  = (remain_ff != '0) && slot_free;

   assign avail   = fill(wr_idx_ff, rd_idx_ff);
   assign limit_x = CW'(limit_ff);
   assign room    = ROOM_MAX - avail;
   assign take    = (CW'(req_pop_count) < avail) ? CW'(req_pop_count) : avail;
   assign take_n  = take[CNT_W-1:0];

   // pop side
   assign rd_next    = bump(rd_idx_ff);
   assign used_rd    = fill(wr_idx_ff, rd_next);
   assign hold_rd    = ((used_rd < limit_x) || !fc_en_ff) ? 1'b0 : hold_ff;
   assign hold_empty = ((avail < limit_x) || !fc_en_ff) ? 1'b0 : hold_ff;

   // push side
   assign new_msg = req_first_of_message || (left_ff == '0);
   always_comb begin
      msg_len = req_first_of_message ? req_message_length : CNT_W'(1);
      if (msg_len == '0) msg_len = CNT_W'(1);
   end
   assign store     = new_msg ? (room >= CW'(msg_len)) : (!drop_ff && (room != '0));
   assign wr_next   = store ? bump(wr_idx_ff) : wr_idx_ff;
   assign used_push = fill(wr_next, rd_idx_ff);
   assign hold_push = !fc_en_ff ? 1'b0 : ((used_push >= limit_x) ? 1'b1 : hold_ff);

   always_comb begin
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      hold_in      = hold_ff;
      drop_in      = drop_ff;
      left_in      = left_ff;
      limit_in     = limit_ff;
      fc_en_in     = fc_en_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      bvalid_in    = bvalid_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      used_in      = used_ff;
      rts_in       = rts_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      if (cont_read) begin
         // next byte of a running pop
         ram_re       = 1'b1;
         rd_idx_in    = rd_next;
         remain_in    = remain_ff - 1'b1;
         rsp_valid_in = 1'b1;
         bvalid_in    = 1'b1;
         last_in      = (remain_ff == CNT_W'(1));
         acc_in       = 1'b0;
         used_in      = used_rd[CNT_W-1:0];
         rts_in       = (remain_ff == CNT_W'(1)) ? hold_rd : hold_ff;
         if (remain_ff == CNT_W'(1)) hold_in = hold_rd;
      end else if (req_accept) begin
         rsp_valid_in = 1'b1;
         if (opcode_type'(req_opcode) == OP_PUSH) begin
            ram_we    = store;
            wr_idx_in = wr_next;
            if (new_msg) begin
               drop_in = !(room >= CW'(msg_len));
               left_in = msg_len - 1'b1;
            end else begin
               left_in = left_ff - 1'b1;
            end
            hold_in   = hold_push;
            bvalid_in = 1'b0;
            last_in   = 1'b1;
            acc_in    = store;
            used_in   = used_push[CNT_W-1:0];
            rts_in    = hold_push;
         end else if (take_n == '0) begin
            // empty fifo or zero count
            hold_in   = hold_empty;
            bvalid_in = 1'b0;
            last_in   = 1'b1;
            acc_in    = 1'b0;
            used_in   = avail[CNT_W-1:0];
            rts_in    = hold_empty;
         end else begin
            ram_re    = 1'b1;
            rd_idx_in = rd_next;
            remain_in = take_n - 1'b1;
            bvalid_in = 1'b1;
            last_in   = (take_n == CNT_W'(1));
            acc_in    = 1'b0;
            used_in   = used_rd[CNT_W-1:0];
            rts_in    = (take_n == CNT_W'(1)) ? hold_rd : hold_ff;
            if (take_n == CNT_W'(1)) hold_in = hold_rd;
         end
      end

      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_THROTTLE_LIMIT: begin
               limit_in = csr_write_data[CNT_W-1:0];
            end
            REG_FLOW_CONTROL_ENABLE: begin
               fc_en_in = csr_write_data[0];
               if (!csr_write_data[0]) hold_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         hold_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         left_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         fc_en_ff     <= 1'b1;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         hold_ff      <= hold_in;
         drop_ff      <= drop_in;
         left_ff      <= left_in;
         limit_ff     <= limit_in;
         fc_en_ff     <= fc_en_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bvalid_ff <= bvalid_in;
      last_ff   <= last_in;
      acc_ff    <= acc_in;
      used_ff   <= used_in;
      rts_ff    <= rts_in;
   end

   brf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (wr_idx_ff),
      .write_data   (req_data_byte),
      .read_enable  (ram_re),
      .read_addr    (rd_idx_ff),
      .read_data    (ram_q)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = bvalid_ff ? ram_q : '0;
   assign rsp_out_valid     = bvalid_ff;
   assign rsp_last_of_run   = last_ff;
   assign rsp_push_accepted = acc_ff;
   assign rsp_used_count    = used_ff;
   assign rsp_rts_hold      = rts_ff;

   // a running pop always has a result on the output
   a_run_has_result: assert property (@(posedge clock) disable iff (reset)
      (remain_ff != '0) |-> rsp_valid_ff)
      else $error("pop run without a pending result");

   // hold flag stays released while flow control is off
   a_hold_off: assert property (@(posedge clock) disable iff (reset)
      !fc_en_ff |-> !hold_ff)
      else $error("hold flag set with flow control disabled");

   // ram read data holds while a popped byte is stalled
   a_byte_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && bvalid_ff && rsp_stall) |=> $stable(ram_q))
      else $error("popped byte changed while stalled");

   // no new read is issued while the output slot is occupied and stalled
   a_no_read_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !ram_re)
      else $error("ram read issued into a stalled output");

endmodule
